### rtl/strict_priority_four_lane_task_queue_top_defines.svh
// Assertion macros for the strict priority four lane task queue.
`ifndef STRICT_PRIORITY_FOUR_LANE_TASK_QUEUE_TOP_DEFINES_SVH
`define STRICT_PRIORITY_FOUR_LANE_TASK_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SPQ_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/spq_pkg.sv
// Types, constants and helper functions shared by the task queue modules.
`timescale 1ns / 1ps

package spq_pkg;

  // Sizing of the lanes and the shared tag store.
  localparam int TOTAL_DEPTH = 64;
  localparam int TAG_BITS    = 16;
  localparam int NUM_LANES   = 4;
  localparam int LANE_W      = 2;
  localparam int OCC_W       = 7;
  localparam int MAXQ_W      = 7;
  localparam int MAXQ_RESET  = 64;
  localparam int PTR_W       = $clog2(TOTAL_DEPTH);
  localparam int CNT_W       = $clog2(TOTAL_DEPTH + 1);
  localparam int LIM_W       = (CNT_W > MAXQ_W) ? CNT_W : MAXQ_W;
  localparam int ADDR_W      = $clog2(NUM_LANES * TOTAL_DEPTH);

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } command_e;

  typedef enum logic [1:0] {
    STS_QUEUED   = 2'd0,
    STS_REJECTED = 2'd1,
    STS_DEQUEUED = 2'd2,
    STS_EMPTY    = 2'd3
  } status_e;

  typedef enum logic {
    CTRL_IDLE = 1'b0,
    CTRL_READ = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    command_e              command;
    logic [LANE_W-1:0]     lane;
    logic [TAG_BITS-1:0]   task_tag;
  } in_item_t;

  typedef struct packed {
    status_e               status;
    logic [TAG_BITS-1:0]   out_tag;
    logic [LANE_W-1:0]     out_lane;
    logic [OCC_W-1:0]      occupancy;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept_op;
    logic load_mem;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic deq_hit;
  } dp_sts_t;

  // Advance a ring pointer, wrapping at the lane depth.
  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(TOTAL_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  // Address of a ring slot in the shared tag store.
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [LANE_W-1:0] l,
                                                  input logic [PTR_W-1:0]  p);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(ADDR_W'(l) * ADDR_W'(TOTAL_DEPTH)) + ADDR_W'(p);
    return a;
  endfunction

endpackage

### rtl/spq_datapath.sv
// Lane pointers, counters, tag store and result register of the task queue.
`timescale 1ns / 1ps

module spq_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [spq_pkg::MAXQ_W-1:0] cfg_wdata_i,
  input  spq_pkg::in_item_t         in_data_i,
  input  spq_pkg::dp_cmd_t          cmd_i,
  output spq_pkg::dp_sts_t          sts_o,
  output spq_pkg::out_item_t        out_data_o
);

  logic [spq_pkg::MAXQ_W-1:0] maxq_q;
  logic [spq_pkg::CNT_W-1:0]  count_q [spq_pkg::NUM_LANES];
  logic [spq_pkg::PTR_W-1:0]  head_q  [spq_pkg::NUM_LANES];
  logic [spq_pkg::PTR_W-1:0]  tail_q  [spq_pkg::NUM_LANES];
  logic [spq_pkg::CNT_W-1:0]  total_q;
  logic [spq_pkg::TAG_BITS-1:0] mem [spq_pkg::NUM_LANES * spq_pkg::TOTAL_DEPTH];
  logic [spq_pkg::TAG_BITS-1:0] rd_data_q;
  spq_pkg::out_item_t         out_q;

  logic [spq_pkg::LIM_W-1:0]  maxq_ext;
  logic [spq_pkg::LIM_W-1:0]  limit;
  logic                       full;
  logic                       is_enq;
  logic                       found;
  logic [spq_pkg::LANE_W-1:0] sel;
  logic                       do_write;
  logic                       do_read;
  logic [spq_pkg::ADDR_W-1:0] wr_addr;
  logic [spq_pkg::ADDR_W-1:0] rd_addr;

  // Admission limit, capped at the store capacity.
  always_comb begin
    maxq_ext = spq_pkg::LIM_W'(maxq_q);
    if (maxq_ext > spq_pkg::LIM_W'(spq_pkg::TOTAL_DEPTH)) begin
      limit = spq_pkg::LIM_W'(spq_pkg::TOTAL_DEPTH);
    end else begin
      limit = maxq_ext;
    end
    full = spq_pkg::LIM_W'(total_q) >= limit;
  end

  // Strict priority pick: the lowest numbered lane that holds a task.
  always_comb begin
    sel = '0;
    for (int i = spq_pkg::NUM_LANES - 1; i >= 0; i--) begin
      if (count_q[i] != '0) begin
        sel = spq_pkg::LANE_W'(i);
      end
    end
    found = total_q != '0;
  end

  assign is_enq   = in_data_i.command == spq_pkg::CMD_ENQ;
  assign do_write = cmd_i.accept_op && is_enq && !full;
  assign do_read  = cmd_i.accept_op && !is_enq && found;
  assign wr_addr  = spq_pkg::slot_addr(in_data_i.lane, tail_q[in_data_i.lane]);
  assign rd_addr  = spq_pkg::slot_addr(sel, head_q[sel]);

  assign sts_o.deq_hit = !is_enq && found;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxq_q <= spq_pkg::MAXQ_W'(spq_pkg::MAXQ_RESET);
    end else if (cfg_we_i) begin
      maxq_q <= cfg_wdata_i;
    end
  end

  // Per-lane pointers and counters, plus the running total.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < spq_pkg::NUM_LANES; i++) begin
        count_q[i] <= '0;
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
      end
      total_q <= '0;
    end else begin
      for (int i = 0; i < spq_pkg::NUM_LANES; i++) begin
        if (do_write && in_data_i.lane == spq_pkg::LANE_W'(i)) begin
          count_q[i] <= count_q[i] + spq_pkg::CNT_W'(1);
          tail_q[i]  <= spq_pkg::ring_next(tail_q[i]);
        end else if (do_read && sel == spq_pkg::LANE_W'(i)) begin
          count_q[i] <= count_q[i] - spq_pkg::CNT_W'(1);
          head_q[i]  <= spq_pkg::ring_next(head_q[i]);
        end
      end
      if (do_write) begin
        total_q <= total_q + spq_pkg::CNT_W'(1);
      end else if (do_read) begin
        total_q <= total_q - spq_pkg::CNT_W'(1);
      end
    end
  end

  // Shared tag store with a registered read port.
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem[wr_addr] <= in_data_i.task_tag;
    end
    if (do_read) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Result register; a dequeue fills in the tag in the cycle after the read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_op) begin
      if (is_enq) begin
        out_q.out_tag  <= in_data_i.task_tag;
        out_q.out_lane <= in_data_i.lane;
        if (full) begin
          out_q.status    <= spq_pkg::STS_REJECTED;
          out_q.occupancy <= spq_pkg::OCC_W'(total_q);
        end else begin
          out_q.status    <= spq_pkg::STS_QUEUED;
          out_q.occupancy <= spq_pkg::OCC_W'(total_q + spq_pkg::CNT_W'(1));
        end
      end else if (found) begin
        out_q.status    <= spq_pkg::STS_DEQUEUED;
        out_q.out_lane  <= sel;
        out_q.occupancy <= spq_pkg::OCC_W'(total_q - spq_pkg::CNT_W'(1));
      end else begin
        out_q.status    <= spq_pkg::STS_EMPTY;
        out_q.out_tag   <= '0;
        out_q.out_lane  <= '0;
        out_q.occupancy <= '0;
      end
    end else if (cmd_i.load_mem) begin
      out_q.out_tag <= rd_data_q;
    end
  end

  assign out_data_o = out_q;

endmodule

### rtl/spq_ctrl.sv
// Handshake controller of the task queue: accepts items and owns result valid.
`timescale 1ns / 1ps

module spq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             out_stall_i,
  input  spq_pkg::dp_sts_t sts_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  output spq_pkg::dp_cmd_t cmd_o
);

  spq_pkg::ctrl_state_e state_q, state_d;
  logic                 out_vld_q, out_vld_d;
  logic                 out_free;

  // The result register is free when empty or when its transfer completes now.
  assign out_free = !out_vld_q || !out_stall_i;

  // State and result valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= spq_pkg::CTRL_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d         = state_q;
    out_vld_d       = out_vld_q && out_stall_i;
    in_stall_o      = 1'b1;
    cmd_o.accept_op = 1'b0;
    cmd_o.load_mem  = 1'b0;
    unique case (state_q)
      spq_pkg::CTRL_IDLE: begin
        in_stall_o = !out_free;
        if (in_valid_i && out_free) begin
          cmd_o.accept_op = 1'b1;
          if (sts_i.deq_hit) begin
            state_d = spq_pkg::CTRL_READ;
          end else begin
            out_vld_d = 1'b1;
          end
        end
      end
      spq_pkg::CTRL_READ: begin
        // Tag read data is ready; move it into the result register.
        cmd_o.load_mem = 1'b1;
        out_vld_d      = 1'b1;
        state_d        = spq_pkg::CTRL_IDLE;
      end
      default: begin
        state_d = spq_pkg::CTRL_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_vld_q;

endmodule

### rtl/strict_priority_four_lane_task_queue_top.sv
// Top level of the strict priority four lane task queue.
`timescale 1ns / 1ps
`include "strict_priority_four_lane_task_queue_top_defines.svh"

// Four FIFO lanes (control, retrieve, lookup, store) share one admission limit
// set by the max_queued register (values above the store capacity act as the
// capacity). Every transfer in gives exactly one result. An enqueue and a
// dequeue that finds all lanes empty fill the whole result on acceptance; a
// dequeue that finds a task adds its tag in the read state, from the shared
// tag store's registered read port. The block holds one item at a time: it
// takes the next item no earlier than the cycle in which the previous result
// is transferred out, so a stalled result holds the input off. The tag store
// needs no clearing after reset: only entries that hold queued tasks are read.
// Write max_queued only while the block is idle.

module strict_priority_four_lane_task_queue_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [spq_pkg::MAXQ_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  spq_pkg::in_item_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output spq_pkg::out_item_t         out_data_o
);

  spq_pkg::dp_cmd_t ctrl_cmd;
  spq_pkg::dp_sts_t dp_sts;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .sts_i       (dp_sts),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (ctrl_cmd)
  );

  spq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (ctrl_cmd),
    .sts_o       (dp_sts),
    .out_data_o  (out_data_o)
  );

  // A dequeue that hits a lane blocks the input while its tag is read.
  `SPQ_ASSERT_NEXT(a_deq_blocks_input, clk_i, rst_ni, ctrl_cmd.accept_op && dp_sts.deq_hit, in_stall_o, "dequeue hit did not hold off the next item")

  // The tag load and a new operation never overlap.
  `SPQ_ASSERT_NOW(a_no_overlap, clk_i, rst_ni, ctrl_cmd.load_mem, !ctrl_cmd.accept_op, "operation accepted during tag load")

  // A tag load follows a dequeue hit and then shows a dequeued result.
  `SPQ_ASSERT_NEXT(a_load_result, clk_i, rst_ni, ctrl_cmd.load_mem, out_valid_o && out_data_o.status == spq_pkg::STS_DEQUEUED, "tag load did not present a dequeued result")

endmodule
